[src/uvst_pkg.sv]
package uvst_pkg;

  // field widths of one transaction
  localparam int MODE_W  = 2;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = 4;
  localparam int CNT_OUT_W = 5;

  // mode codes on in_tuser
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  // command queue depth (power of two)
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_QUERY,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_ACT,
    BK_MOVE,
    BK_READ,
    BK_DONE
  } bk_state_t;

endpackage

[src/uvst_front.sv]
module uvst_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [uvst_pkg::MODE_W-1:0] in_mode,
  input  logic [uvst_pkg::VAL_W-1:0]  in_value,
  input  logic [uvst_pkg::IDX_W-1:0]  in_index,
  output logic                      push_valid,
  input  logic                      push_ready,
  output uvst_pkg::cmd_t            push_cmd
);
  import uvst_pkg::*;

  logic fv_r, fv_nxt;
  cmd_t fcmd_r, fcmd_nxt;
  op_t  op_dec;
  logic accept;

  // mode decode
  always_comb begin
    case (in_mode)
      MODE_ADD:    op_dec = OP_ADD;
      MODE_REMOVE: op_dec = OP_REMOVE;
      MODE_QUERY:  op_dec = OP_QUERY;
      MODE_READ:   op_dec = OP_READ;
      default:     op_dec = OP_QUERY;
    endcase
  end

  assign in_ready = !fv_r || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    fv_nxt   = fv_r;
    fcmd_nxt = fcmd_r;
    if (accept) begin
      fv_nxt         = 1'b1;
      fcmd_nxt.op    = op_dec;
      fcmd_nxt.value = in_value;
      fcmd_nxt.index = in_index;
    end else if (push_ready) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
    fcmd_r <= fcmd_nxt;
  end

  assign push_valid = fv_r;
  assign push_cmd   = fcmd_r;

endmodule

[src/uvst_queue.sv]
module uvst_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  uvst_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output uvst_pkg::cmd_t pop_cmd
);
  import uvst_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  cmd_t           slots_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign push_ready = (fill_r != (QAW+1)'(QDEPTH));
  assign pop_valid  = (fill_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slots_r[rp_r];

  always_comb begin
    wp_nxt   = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt   = do_pop  ? rp_r + 1'b1 : rp_r;
    fill_nxt = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
    if (do_push) begin
      slots_r[wp_r] <= push_cmd;
    end
  end

endmodule

[src/uvst_back.sv]
module uvst_back #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  uvst_pkg::cmd_t                pop_cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic                          out_dropped,
  output logic [uvst_pkg::VAL_W-1:0]     out_data,
  output logic [uvst_pkg::CNT_OUT_W-1:0] out_count
);
  import uvst_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] mem_q;

  bk_state_t state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          issue_r, issue_nxt;
  logic                   rdv_r, rdv_nxt;
  logic [AW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]          slot_r, slot_nxt;
  logic                   found_r, found_nxt;
  logic                   dropped_r, dropped_nxt;
  logic [VAL_W-1:0]       data_r, data_nxt;
  logic                   rd_zero_r, rd_zero_nxt;
  logic                   slot0_w_r, slot0_w_nxt;

  logic                   ov_r, ov_nxt;
  logic                   of_r, of_nxt, od_r, od_nxt;
  logic [VAL_W-1:0]       odata_r, odata_nxt;
  logic [CNT_OUT_W-1:0]   ocnt_r, ocnt_nxt;

  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   match;
  logic [CMPW-1:0]        idx_ext, cnt_ext;
  logic                   in_range;
  logic [CW-1:0]          last_slot;

  assign match     = rdv_r && (mem_q == val_r);
  assign idx_ext   = CMPW'(idx_r);
  assign cnt_ext   = CMPW'(count_r);
  assign in_range  = idx_ext < cnt_ext;
  assign last_slot = count_r - 1'b1;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    issue_nxt   = issue_r;
    rdv_nxt     = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    slot_nxt    = slot_r;
    found_nxt   = found_r;
    dropped_nxt = dropped_r;
    data_nxt    = data_r;
    rd_zero_nxt = rd_zero_r;
    ov_nxt      = ov_r && !out_ready;
    of_nxt      = of_r;
    od_nxt      = od_r;
    odata_nxt   = odata_r;
    ocnt_nxt    = ocnt_r;
    pop_ready   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          op_nxt      = pop_cmd.op;
          val_nxt     = VALUE_WIDTH'(pop_cmd.value);
          idx_nxt     = pop_cmd.index;
          issue_nxt   = '0;
          found_nxt   = 1'b0;
          dropped_nxt = 1'b0;
          data_nxt    = '0;
          state_nxt   = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (match) begin
          found_nxt = 1'b1;
          slot_nxt  = cmp_idx_r;
          state_nxt = BK_ACT;
        end else if (issue_r < count_r) begin
          rd_en       = 1'b1;
          rd_addr     = issue_r[AW-1:0];
          rdv_nxt     = 1'b1;
          cmp_idx_nxt = issue_r[AW-1:0];
          issue_nxt   = issue_r + 1'b1;
        end else begin
          state_nxt = BK_ACT;
        end
      end
      BK_ACT: begin
        case (op_r)
          OP_ADD: begin
            if (!found_r) begin
              if (count_r >= CW'(CAPACITY)) begin
                dropped_nxt = 1'b1;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_data   = val_r;
                count_nxt = count_r + 1'b1;
              end
            end
            state_nxt = BK_DONE;
          end
          OP_REMOVE: begin
            if (found_r) begin
              rd_en     = 1'b1;
              rd_addr   = last_slot[AW-1:0];
              state_nxt = BK_MOVE;
            end else begin
              state_nxt = BK_DONE;
            end
          end
          OP_READ: begin
            rd_en       = 1'b1;
            rd_addr     = in_range ? idx_ext[AW-1:0] : '0;
            rd_zero_nxt = !in_range && !slot0_w_r;
            state_nxt   = BK_READ;
          end
          default: begin
            state_nxt = BK_DONE;
          end
        endcase
      end
      BK_MOVE: begin
        // last entry fills the hole
        wr_en     = 1'b1;
        wr_addr   = slot_r;
        wr_data   = mem_q;
        count_nxt = count_r - 1'b1;
        state_nxt = BK_DONE;
      end
      BK_READ: begin
        data_nxt  = rd_zero_r ? '0 : VAL_W'(mem_q);
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          of_nxt    = found_r;
          od_nxt    = dropped_r;
          odata_nxt = data_r;
          ocnt_nxt  = CNT_OUT_W'(count_r);
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign slot0_w_nxt = slot0_w_r || (wr_en && (wr_addr == '0));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      count_r   <= '0;
      rdv_r     <= 1'b0;
      slot0_w_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rdv_r     <= rdv_nxt;
      slot0_w_r <= slot0_w_nxt;
      ov_r      <= ov_nxt;
    end
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    issue_r   <= issue_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
    found_r   <= found_nxt;
    dropped_r <= dropped_nxt;
    data_r    <= data_nxt;
    rd_zero_r <= rd_zero_nxt;
    of_r      <= of_nxt;
    od_r      <= od_nxt;
    odata_r   <= odata_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  assign out_valid   = ov_r;
  assign out_found   = of_r;
  assign out_dropped = od_r;
  assign out_data    = odata_r;
  assign out_count   = ocnt_r;

endmodule

[src/unique_value_set_table_unit.sv]
// Set of up to CAPACITY distinct values. Each input transaction carries a
// mode on in_tuser (add, remove, membership query, read at index) and a value
// and index on in_tdata; each gives exactly one result transaction with found,
// data, count and dropped. Add appends an absent value, or sets dropped when
// the set is full. Remove moves the last entry into the freed slot. Read out
// of range returns slot 0 as it stands (zero until first written). Values are
// masked to VALUE_WIDTH bits. Every operation first searches the stored
// entries, a match ending the search early; add and query then pass the act
// and done states, and read and a found remove also a read or move state.
// The linear search reads the single-port entry memory one slot per cycle,
// compared in the cycle after the read. A two-deep command queue sits between
// the input decode and the search engine, so input transactions keep being
// taken, until it fills, while the engine works and while a result waits on
// out_tready. The store is empty straight out of reset; no clearing pass.
module unique_value_set_table_unit #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [35:32] index, [39:36] zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] data, [36:32] count, [39:37] zero
  output logic [1:0]  out_tuser   // [0] found, [1] dropped
);
  import uvst_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  logic                 res_found, res_dropped;
  logic [VAL_W-1:0]     res_data;
  logic [CNT_OUT_W-1:0] res_count;

  // decode and register incoming transactions
  uvst_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser),
    .in_value   (in_tdata[VAL_W-1:0]),
    .in_index   (in_tdata[VAL_W+IDX_W-1:VAL_W]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // decouples decode from the search engine
  uvst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // search, update and result register
  uvst_back #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_cmd     (pop_cmd),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_found   (res_found),
    .out_dropped (res_dropped),
    .out_data    (res_data),
    .out_count   (res_count)
  );

  assign out_tdata = {3'b000, res_count, res_data};
  assign out_tuser = {res_dropped, res_found};

endmodule

[verif/tb_unique_value_set_table_unit.sv]
`timescale 1ns / 1ps

module tb_unique_value_set_table_unit;
  import uvst_pkg::*;

  localparam int SET_CAPACITY   = 16;
  // cycles with no transaction on either side before the run is abandoned;
  // worst case per op is a long sender gap plus a long receiver stall plus
  // a full 16-entry scan, well under this
  localparam int WATCHDOG_LIMIT = 3000;
  // drain time after the last result
  localparam int TAIL_CYCLES    = 40;

  // one set operation as it goes into the block
  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  index;
  } set_op_t;

  // one answer as it should come out
  typedef struct {
    logic                 found;
    logic [VAL_W-1:0]     data;
    logic [CNT_OUT_W-1:0] count;
    logic                 dropped;
  } set_answer_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [31:0] value, [35:32] index, [39:36] zero
  logic [1:0]  in_tuser   = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] data, [36:32] count, [39:37] zero
  logic [1:0]  out_tuser;         // [0] found, [1] dropped

  unique_value_set_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the set: slot contents and occupancy. Slots above the
  // count keep stale data, as in the block, since an out-of-range read
  // returns slot 0 whatever it holds.
  // ---------------------------------------------------------------------
  logic [VAL_W-1:0] shadow_slots [SET_CAPACITY] = '{default: '0};
  int unsigned      shadow_size = 0;

  set_op_t     op_queue [$];      // operations waiting to be driven
  set_answer_t answer_queue [$];  // answers owed by the block, oldest first

  int mismatch_cnt = 0;
  int idle_cycles  = 0;

  // Applies one accepted operation to the shadow set and returns the answer.
  function automatic set_answer_t apply_set_op(set_op_t op);
    set_answer_t ans;
    int          hit;
    hit = -1;
    for (int i = 0; i < int'(shadow_size); i++)
      if (hit < 0 && shadow_slots[i] == op.value) hit = i;
    ans.found   = (hit >= 0);
    ans.data    = '0;
    ans.dropped = 1'b0;
    case (op.mode)
      MODE_ADD: begin
        if (hit < 0) begin
          if (shadow_size >= SET_CAPACITY) begin
            ans.dropped = 1'b1;
          end else begin
            shadow_slots[shadow_size] = op.value;
            shadow_size++;
          end
        end
      end
      MODE_REMOVE: begin
        // last entry fills the hole
        if (hit >= 0) begin
          shadow_slots[hit] = shadow_slots[shadow_size - 1];
          shadow_size--;
        end
      end
      MODE_READ: begin
        ans.data = (op.index < shadow_size) ? shadow_slots[op.index] : shadow_slots[0];
      end
      default: ;
    endcase
    ans.count = shadow_size[CNT_OUT_W-1:0];
    return ans;
  endfunction

  // Idle length for either side: mostly none, some short, a few long.
  // A calm side never idles, giving back-to-back stretches.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic queue_op(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] value,
                          logic [IDX_W-1:0] index);
    set_op_t op;
    op.mode  = mode;
    op.value = value;
    op.index = index;
    op_queue.push_back(op);
  endtask

  // Waits until every queued op has been taken and answered; sampled on the
  // falling edge so the driver's and monitor's updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (op_queue.size() != 0 || in_tvalid || answer_queue.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued operations, predicts on acceptance.
  // ---------------------------------------------------------------------
  set_op_t drv_op;
  int      drv_gap  = 0;
  bit      drv_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        answer_queue.push_back(apply_set_op(drv_op));
      if ($urandom_range(0, 199) == 0) drv_calm = !drv_calm;
      // channel is free this cycle unless a transaction is still held
      if (!in_tvalid || in_tready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_tvalid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          drv_op    = op_queue.pop_front();
          in_tdata  <= {4'b0000, drv_op.index, drv_op.value};
          in_tuser  <= drv_op.mode;
          in_tvalid <= 1'b1;
          drv_gap   = pick_gap(drv_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, compares every result transaction.
  // ---------------------------------------------------------------------
  set_answer_t mon_exp;
  int          mon_stall = 0;
  bit          mon_calm  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (answer_queue.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: found=%0b data=%h count=%0d dropped=%0b",
                     out_tuser[0], out_tdata[31:0], out_tdata[36:32], out_tuser[1]);
        end else begin
          mon_exp = answer_queue.pop_front();
          if (out_tuser[0] !== mon_exp.found || out_tdata[31:0] !== mon_exp.data ||
              out_tdata[36:32] !== mon_exp.count || out_tuser[1] !== mon_exp.dropped) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp found=%0b data=%h count=%0d dropped=%0b | got found=%0b data=%h count=%0d dropped=%0b",
                       mon_exp.found, mon_exp.data, mon_exp.count, mon_exp.dropped,
                       out_tuser[0], out_tdata[31:0], out_tdata[36:32], out_tuser[1]);
          end
        end
      end
      if ($urandom_range(0, 199) == 0) mon_calm = !mon_calm;
      if (mon_stall > 0) begin
        mon_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) mon_stall = pick_gap(mon_calm);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: any transaction on either side resets the count.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  logic [VAL_W-1:0]  pool [24];
  int                pool_n;
  int                add_w;
  int                rem_w;
  int                r;
  logic [MODE_W-1:0] mode_pick;
  logic [VAL_W-1:0]  val_pick;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty set, stale slot 0 read and lookup, absent remove
    queue_op(MODE_READ,   32'h0000_0000, 4'd0);
    queue_op(MODE_QUERY,  32'h0000_0000, 4'd15);
    queue_op(MODE_REMOVE, 32'h0000_0005, 4'd0);
    // top value, re-add of a present value, reads in and out of range
    queue_op(MODE_ADD,    32'hFFFF_FFFF, 4'd0);
    queue_op(MODE_ADD,    32'hFFFF_FFFF, 4'd0);
    queue_op(MODE_READ,   32'h0000_0000, 4'd0);
    queue_op(MODE_READ,   32'h0000_0000, 4'd15);
    // fill to capacity, zero among the values
    for (int i = 0; i < 15; i++)
      queue_op(MODE_ADD, 32'h0001_0001 * i, 4'd0);
    // full: absent add dropped, present add just found
    queue_op(MODE_ADD,    32'h1234_5678, 4'd0);
    queue_op(MODE_ADD,    32'h0000_0000, 4'd0);
    // remove from the middle, last entry moves into slot 6
    queue_op(MODE_REMOVE, 32'h0005_0005, 4'd0);
    queue_op(MODE_READ,   32'h0000_0000, 4'd5);

    // hold the sender until the directed answers are all back
    wait_drained();

    // random: phases over small value pools so adds and removes hit,
    // alternating fill-heavy, drain-heavy and balanced mixes
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: pool_n = 3;
        1: pool_n = 10;
        2: pool_n = 17;
        default: pool_n = 24;
      endcase
      for (int k = 0; k < pool_n; k++)
        pool[k] = ($urandom_range(0, 4) == 0) ? 32'(k) : $urandom;
      case (ph % 3)
        0: begin add_w = 60; rem_w = 15; end
        1: begin add_w = 15; rem_w = 55; end
        default: begin add_w = 35; rem_w = 30; end
      endcase
      for (int n = 0; n < 125; n++) begin
        r = $urandom_range(0, 99);
        if (r < add_w) mode_pick = MODE_ADD;
        else if (r < add_w + rem_w) mode_pick = MODE_REMOVE;
        else if (r < add_w + rem_w + 12) mode_pick = MODE_QUERY;
        else mode_pick = MODE_READ;
        // a tenth is noise: any value
        if ($urandom_range(0, 9) == 0) val_pick = $urandom;
        else val_pick = pool[$urandom_range(0, pool_n - 1)];
        queue_op(mode_pick, val_pick, 4'($urandom_range(0, 15)));
      end
      while (op_queue.size() != 0) @(posedge clk);
      if (ph % 2 == 1)
        wait_drained();
    end

    // let the last transaction go, then drain
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && answer_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[unique_value_set_table_unit.f]
src/uvst_pkg.sv
src/uvst_front.sv
src/uvst_queue.sv
src/uvst_back.sv
src/unique_value_set_table_unit.sv
verif/tb_unique_value_set_table_unit.sv
